// ----- design/char_lcd_4bit_expander_sequencer_defines.svh -----
// Assertion macros shared by the checker.
`ifndef CHAR_LCD_4BIT_EXPANDER_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_EXPANDER_SEQUENCER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define LCDX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define LCDX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lcdx_pkg.sv -----
`timescale 1ns / 1ps
package lcdx_pkg;

  typedef logic [12:0] wait_t;

  // operation codes
  localparam logic [2:0] OP_INIT      = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_HOME      = 3'd2;
  localparam logic [2:0] OP_SET_CUR   = 3'd3;
  localparam logic [2:0] OP_WRITE_CHR = 3'd4;
  localparam logic [2:0] OP_BACKLIGHT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] REG_BL_AT_INIT   = 2'd2;

  // job kinds for the back end
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_INIT = 2'd1;
  localparam logic [1:0] KIND_BL   = 2'd2;

  // LCD commands
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // phase within a nibble
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_EHIGH = 2'd1;
  localparam logic [1:0] PH_ELOW  = 2'd2;

  localparam wait_t WAIT_EHIGH_US  = 13'd1;
  localparam wait_t WAIT_NIBBLE_US = 13'd50;
  localparam wait_t WAIT_LONG_US   = 13'd2000;
  localparam wait_t WAIT_WAKE_US   = 13'd4500;
  localparam wait_t WAIT_WAKE3_US  = 13'd150;

  localparam logic [3:0] INIT_LAST_NIB = 4'd11;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       rs;
    logic       bl;
    logic       long_wait;   // clear/home: extra hold on the final byte
  } job_t;

  function automatic logic [6:0] row_base(input logic [1:0] row);
    case (row)
      2'd0:    row_base = 7'h00;
      2'd1:    row_base = 7'h40;
      2'd2:    row_base = 7'h14;
      default: row_base = 7'h54;
    endcase
  endfunction

  // wake-up nibbles, then 0x28, 0x0C, 0x01, 0x06 split high/low
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd1, 4'd2: init_nibble = 4'h3;
      4'd3, 4'd4:       init_nibble = 4'h2;
      4'd5:             init_nibble = 4'h8;
      4'd7:             init_nibble = 4'hC;
      4'd9:             init_nibble = 4'h1;
      4'd11:            init_nibble = 4'h6;
      default:          init_nibble = 4'h0;
    endcase
  endfunction

  function automatic wait_t init_extra(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd1: init_extra = WAIT_WAKE_US;
      4'd2:       init_extra = WAIT_WAKE3_US;
      4'd9:       init_extra = WAIT_LONG_US;   // low nibble of clear
      default:    init_extra = '0;
    endcase
  endfunction

endpackage

// ----- design/lcdx_queue.sv -----
`timescale 1ns / 1ps
module lcdx_queue import lcdx_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- design/lcdx_front.sv -----
`timescale 1ns / 1ps
module lcdx_front import lcdx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        push,
  output job_t        push_job,
  input  logic        q_full
);

  logic [2:0] row_count_r;
  logic [5:0] column_count_r;
  logic       bl_at_init_r;
  logic       backlight_on_r, backlight_on_nxt;

  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic [7:0] cursor_column;
  logic [7:0] cursor_row;
  logic       accept;
  logic [2:0] rows_eff;
  logic [5:0] cols_eff;
  logic [1:0] row_clamp;
  logic [5:0] col_clamp;
  logic [7:0] addr_sum;

  assign opcode        = in_tdata[2:0];
  assign data_byte     = in_tdata[10:3];
  assign cursor_column = in_tdata[18:11];
  assign cursor_row    = in_tdata[26:19];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (row_count_r == 3'd0) begin
      rows_eff = 3'd1;
    end else if (row_count_r > 3'd4) begin
      rows_eff = 3'd4;
    end else begin
      rows_eff = row_count_r;
    end
    cols_eff  = (column_count_r == 6'd0) ? 6'd1 : column_count_r;
    row_clamp = (cursor_row >= {5'd0, rows_eff}) ? 2'(rows_eff - 3'd1) : cursor_row[1:0];
    col_clamp = (cursor_column >= {2'd0, cols_eff}) ? cols_eff - 6'd1 : cursor_column[5:0];
    addr_sum  = {2'd0, col_clamp} + {1'b0, row_base(row_clamp)};
  end

  // classify the item into a job for the back end
  always_comb begin
    push             = accept;
    backlight_on_nxt = backlight_on_r;
    push_job.kind      = KIND_BYTE;
    push_job.value     = data_byte;
    push_job.rs        = 1'b0;
    push_job.bl        = backlight_on_r;
    push_job.long_wait = 1'b0;
    case (opcode)
      OP_INIT: begin
        push_job.kind = KIND_INIT;
        push_job.bl   = bl_at_init_r;
        if (accept) begin
          backlight_on_nxt = bl_at_init_r;
        end
      end
      OP_CLEAR: begin
        push_job.value     = CMD_CLEAR;
        push_job.long_wait = 1'b1;
      end
      OP_HOME: begin
        push_job.value     = CMD_HOME;
        push_job.long_wait = 1'b1;
      end
      OP_SET_CUR: begin
        push_job.value = CMD_SET_ADDR | addr_sum;
      end
      OP_WRITE_CHR: begin
        push_job.rs = 1'b1;
      end
      OP_BACKLIGHT: begin
        push_job.kind = KIND_BL;
        push_job.bl   = data_byte[0];
        if (accept) begin
          backlight_on_nxt = data_byte[0];
        end
      end
      default: begin
        push = 1'b0;   // unused opcodes are taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 3'd2;
      column_count_r <= 6'd16;
      bl_at_init_r   <= 1'b1;
      backlight_on_r <= 1'b0;
    end else begin
      backlight_on_r <= backlight_on_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count_r    <= cfg_data[2:0];
          REG_COLUMN_COUNT: column_count_r <= cfg_data[5:0];
          REG_BL_AT_INIT:   bl_at_init_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- design/lcdx_back.sv -----
`timescale 1ns / 1ps
module lcdx_back import lcdx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic [1:0] ph_r, ph_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  wait_t      out_wait_r;
  logic       out_last_r;

  logic       adv;
  logic       issue;
  logic       done;
  logic [3:0] nibble;
  logic [7:0] base_byte;
  logic [7:0] cur_byte;
  wait_t      extra;
  wait_t      cur_wait;
  logic       last_nib;
  logic       cur_last;

  assign adv   = !out_valid_r || out_tready;
  assign issue = busy_r && adv;
  assign done  = issue && cur_last;
  assign pop   = !q_empty && (!busy_r || done);

  always_comb begin
    if (job_r.kind == KIND_INIT) begin
      nibble   = init_nibble(nib_r);
      extra    = init_extra(nib_r);
      last_nib = (nib_r == INIT_LAST_NIB);
    end else begin
      nibble   = nib_r[0] ? job_r.value[3:0] : job_r.value[7:4];
      extra    = (job_r.long_wait && nib_r[0]) ? WAIT_LONG_US : '0;
      last_nib = nib_r[0];
    end
    base_byte = {nibble, job_r.bl, 2'b00, job_r.rs};
    case (ph_r)
      PH_SETUP: begin
        cur_byte = base_byte;
        cur_wait = '0;
      end
      PH_EHIGH: begin
        cur_byte = base_byte | 8'h04;
        cur_wait = WAIT_EHIGH_US;
      end
      default: begin
        cur_byte = base_byte;
        cur_wait = WAIT_NIBBLE_US + extra;
      end
    endcase
    cur_last = last_nib && (ph_r == PH_ELOW);
    // backlight-only item: one byte, no enable pulse
    if (job_r.kind == KIND_BL) begin
      cur_byte = {4'h0, job_r.bl, 3'b000};
      cur_wait = '0;
      cur_last = 1'b1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    nib_nxt  = nib_r;
    ph_nxt   = ph_r;
    if (issue) begin
      if (ph_r == PH_ELOW) begin
        ph_nxt  = PH_SETUP;
        nib_nxt = nib_r + 4'd1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      job_nxt  = q_job;
      nib_nxt  = '0;
      ph_nxt   = PH_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      nib_r       <= '0;
      ph_r        <= PH_SETUP;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      nib_r  <= nib_nxt;
      ph_r   <= ph_nxt;
      if (adv) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (issue) begin
      out_byte_r <= cur_byte;
      out_wait_r <= cur_wait;
      out_last_r <= cur_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_wait_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- design/char_lcd_4bit_expander_sequencer.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Content
// in_     | in        | in_tvalid / in_tready  | tdata: opcode, data_byte, cursor_column, cursor_row
// out_    | out       | out_tvalid / out_tready| tdata: expander_byte, wait_after_us; tlast: last
// cfg_    | in        | cfg_valid / cfg_ready  | cfg_index selects register, cfg_data value
//
// The back-end sequencer emits one expander byte per cycle unless out_tready stalls it:
// 6 bytes for a write or command item, 36 for init, 1 for backlight, none for unused opcodes.
// A queue of QUEUE_DEPTH jobs lets the front take items while the back is busy.
// Reset (rst_n low, synchronous) empties queue and output, loads register defaults.
// out_tready low while out_tvalid is high holds the output register and stalls the sequencer in place.
module char_lcd_4bit_expander_sequencer import lcdx_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[2:0], data_byte[10:3], cursor_column[18:11],
                                  // cursor_row[26:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // expander_byte[7:0], wait_after_us[20:8]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t pop_job;
  logic q_empty;

  lcdx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  lcdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  lcdx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- design/lcdx_checker.sv -----
`timescale 1ns / 1ps
`include "char_lcd_4bit_expander_sequencer_defines.svh"
module lcdx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  `LCDX_ASSERT_NEXT(a_out_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped while stalled")
  `LCDX_ASSERT_NEXT(a_out_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")
  // pin 1 of the expander is never driven
  `LCDX_ASSERT_NOW(a_unused_pin, clk, rst_n, out_tvalid, out_tdata[1] == 1'b0, "expander bit 1 set")
  // enable-high byte is never the end of an item and always holds 1 us
  `LCDX_ASSERT_NOW(a_enable_pulse, clk, rst_n, out_tvalid && out_tdata[2], !out_tlast && out_tdata[20:8] == 13'd1, "bad enable-high byte")

endmodule

bind char_lcd_4bit_expander_sequencer lcdx_checker u_lcdx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
